[design/pzv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package pzv_pkg;

  // Sizes and number formats
  localparam int DIM_BITS        = 14;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int OFS_FRAC        = 8;
  localparam int SCALE_W         = 5 + SCALE_FRAC_BITS;
  localparam int RECT_W          = 22;
  localparam int PAN_W           = 32;
  localparam int MAP_W           = 32;
  localparam int SHOWN_SH        = SCALE_FRAC_BITS - OFS_FRAC;
  localparam int SHOWN_W         = SCALE_W + DIM_BITS - SHOWN_SH;
  localparam int DIFF_W          = PAN_W + 1;
  localparam int PROD_W          = DIFF_W + SCALE_W + 1;
  localparam int WIDE_W          = PROD_W + 1;
  localparam int NUM_W           = PROD_W - 1;
  localparam int DEN_W           = SCALE_W;
  localparam int CNT_W           = $clog2(NUM_W + 1);

  // Scale constants
  localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC_BITS;
  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};
  localparam logic [SCALE_W-1:0] ZOOM_HI   = SCALE_W'(20 * (1 << SCALE_FRAC_BITS));
  localparam logic [SCALE_W-1:0] ZOOM_LO   = SCALE_W'(((1 << SCALE_FRAC_BITS) + 5) / 10);
  localparam int ZOOM_UP_MUL   = 100;
  localparam int ZOOM_UP_BIAS  = 47;
  localparam int ZOOM_UP_DEN   = 95;
  localparam int ZOOM_DN_MUL   = 95;
  localparam int ZOOM_DN_BIAS  = 50;
  localparam int ZOOM_DN_DEN   = 100;

  localparam logic signed [WIDE_W-1:0] S32_MAX   = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] S32_MIN   = WIDE_W'(-64'sd2147483648);
  localparam logic signed [WIDE_W-1:0] SCALE_MAXW = $signed(WIDE_W'(SCALE_MAX));
  localparam logic signed [WIDE_W-1:0] RECT_MAXW =
    $signed(WIDE_W'({RECT_W{1'b1}}));

  typedef enum logic [2:0] {
    REQ_LAYOUT   = 3'd0,
    REQ_ZOOM_IN  = 3'd1,
    REQ_ZOOM_OUT = 3'd2,
    REQ_MOVE     = 3'd3,
    REQ_FIT      = 3'd4,
    REQ_FREE     = 3'd5,
    REQ_MAP      = 3'd6
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_ZOOM_DIV, ST_FIT_X, ST_FIT_Y, ST_PAN_X, ST_PAN_Y,
    ST_SHOWN_X, ST_SHOWN_Y, ST_RECT_X, ST_SPOS_X, ST_SLEN_X, ST_RECT_Y,
    ST_SPOS_Y, ST_SLEN_Y, ST_MAP_X, ST_MAP_Y, ST_OUT
  } st_t;

  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] mag;
    logic [DEN_W-1:0] den;
  } div_req_t;

  function automatic logic [PAN_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    t = v;
    if (v > S32_MAX) t = S32_MAX;
    else if (v < S32_MIN) t = S32_MIN;
    return t[PAN_W-1:0];
  endfunction

  function automatic logic [SCALE_W-1:0] sat_scale(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    t = v;
    if (v < 0) t = '0;
    else if (v > SCALE_MAXW) t = SCALE_MAXW;
    return t[SCALE_W-1:0];
  endfunction

  function automatic logic [RECT_W-1:0] rect_clamp(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    t = v;
    if (v < 0) t = '0;
    else if (v > RECT_MAXW) t = RECT_MAXW;
    return t[RECT_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/pzv_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module pzv_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  pzv_pkg::div_req_t            req,
  output logic                         done,
  output logic signed [pzv_pkg::NUM_W:0] quo
);
  import pzv_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic             neg_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;

  // One restoring step: shift in the next numerator bit, try the subtract
  assign shifted = {rem_r, quo_r[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = req.mag;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (!trial[DEN_W+1]) begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold operands
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) begin
      den_r <= req.den;
      neg_r <= req.neg;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule
`default_nettype wire

[design/pan_zoom_viewport.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pan/zoom viewport: keeps scale, pan offset and source/destination
// rectangles for showing an image in a window.
// Configuration: write image and window sizes on cfg_wr_en with cfg_index
// (0 image width, 1 image height, 2 window width, 3 window height) while idle.
// Input channel: in_valid/in_stall carry one request word (type and point).
// Output channel: out_valid/out_stall carry one result word per request.
// One request is in flight at a time; in_stall is high from acceptance until
// the result word is taken. Each division runs on the shared bit-serial
// divider, and size and rectangle updates follow: a map takes 2 divisions,
// a move up to 4, a zoom up to 7, a fit layout up to 8.
// The next request is taken only after the result word is taken, so
// receiver stalls on the result word hold back the next request.
// The result word holds its value while out_stall is high.
// Reset (synchronous, rst_n low) sets scale 1.0, fit mode, pan and
// rectangles to zero and all sizes to zero; the block is ready at once.
module pan_zoom_viewport (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_wr_en,
  input  wire  [1:0]                     cfg_index,
  input  wire  [pzv_pkg::DIM_BITS-1:0]   cfg_wdata,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire  [2:0]                     in_req_type,
  input  wire  signed [15:0]             in_point_x,
  input  wire  signed [15:0]             in_point_y,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic [pzv_pkg::RECT_W-1:0]     out_src_x,
  output logic [pzv_pkg::RECT_W-1:0]     out_src_y,
  output logic [pzv_pkg::RECT_W-1:0]     out_src_w,
  output logic [pzv_pkg::RECT_W-1:0]     out_src_h,
  output logic [pzv_pkg::RECT_W-1:0]     out_dst_x,
  output logic [pzv_pkg::RECT_W-1:0]     out_dst_y,
  output logic [pzv_pkg::RECT_W-1:0]     out_dst_w,
  output logic [pzv_pkg::RECT_W-1:0]     out_dst_h,
  output logic [pzv_pkg::SCALE_W-1:0]    out_scale_now,
  output logic signed [pzv_pkg::MAP_W-1:0] out_image_x,
  output logic signed [pzv_pkg::MAP_W-1:0] out_image_y,
  output logic                           out_fit_active
);
  import pzv_pkg::*;

  st_t state_r, state_nxt;

  logic [DIM_BITS-1:0] iw_r, ih_r, cw_r, ch_r;
  req_t                req_r;
  logic signed [15:0]  px_r, py_r, ptx_r, pty_r;
  logic signed [PAN_W-1:0] pan_x_r, pan_y_r;
  logic [SCALE_W-1:0]  scale_r, tgt_r;
  logic [SHOWN_W-1:0]  shown_w_r, shown_h_r;
  logic [RECT_W-1:0]   src_x_r, src_y_r, src_w_r, src_h_r;
  logic [RECT_W-1:0]   dst_x_r, dst_y_r, dst_w_r, dst_h_r;
  logic [MAP_W-1:0]    map_x_r, map_y_r;
  logic                fit_r, laid_r, launched_r;

  logic                sizes_ok;
  logic [DEN_W-1:0]    den_scale, den_v;
  logic signed [WIDE_W-1:0] pan_xw, pan_yw, cxw, cyw, shw, shh, num_s, num_abs, qw;
  logic signed [DIFF_W-1:0] diff_x, diff_y, diff_sel;
  logic signed [PROD_W-1:0] pan_prod;
  logic [SCALE_W+DIM_BITS-1:0] shown_prod;
  logic                is_div, big_x, big_y;
  div_req_t            div_req;
  logic                div_done;
  logic signed [NUM_W:0] div_quo;

  assign sizes_ok  = (iw_r != '0) && (ih_r != '0) && (cw_r != '0) && (ch_r != '0);
  assign den_scale = (scale_r == '0) ? DEN_W'(1) : scale_r;
  assign pan_xw    = WIDE_W'(pan_x_r);
  assign pan_yw    = WIDE_W'(pan_y_r);
  assign cxw       = $signed(WIDE_W'({cw_r, 8'b0}));
  assign cyw       = $signed(WIDE_W'({ch_r, 8'b0}));
  assign shw       = $signed(WIDE_W'(shown_w_r));
  assign shh       = $signed(WIDE_W'(shown_h_r));
  assign big_x     = shw > cxw;
  assign big_y     = shh > cyw;
  assign qw        = WIDE_W'(div_quo);

  // Pan about the zoom point: (pan - p) * new scale
  assign diff_x   = DIFF_W'(pan_x_r) - (DIFF_W'(ptx_r) <<< OFS_FRAC);
  assign diff_y   = DIFF_W'(pan_y_r) - (DIFF_W'(pty_r) <<< OFS_FRAC);
  assign diff_sel = (state_r == ST_PAN_Y) ? diff_y : diff_x;
  assign pan_prod = diff_sel * $signed({1'b0, tgt_r});

  // Shown size = scale * image size
  assign shown_prod = scale_r * ((state_r == ST_SHOWN_Y) ? ih_r : iw_r);

  // Select the divider operands for the current step
  always_comb begin
    num_s = '0;
    den_v = den_scale;
    unique case (state_r)
      ST_ZOOM_DIV: begin
        if (req_r == REQ_ZOOM_IN) begin
          num_s = $signed(WIDE_W'(scale_r)) * $signed(WIDE_W'(ZOOM_UP_MUL))
                  + $signed(WIDE_W'(ZOOM_UP_BIAS));
          den_v = DEN_W'(ZOOM_UP_DEN);
        end else begin
          num_s = $signed(WIDE_W'(scale_r)) * $signed(WIDE_W'(ZOOM_DN_MUL))
                  + $signed(WIDE_W'(ZOOM_DN_BIAS));
          den_v = DEN_W'(ZOOM_DN_DEN);
        end
      end
      ST_FIT_X: begin
        num_s = $signed(WIDE_W'(cw_r)) <<< SCALE_FRAC_BITS;
        den_v = DEN_W'(iw_r);
      end
      ST_FIT_Y: begin
        num_s = $signed(WIDE_W'(ch_r)) <<< SCALE_FRAC_BITS;
        den_v = DEN_W'(ih_r);
      end
      ST_PAN_X, ST_PAN_Y: num_s = WIDE_W'(pan_prod);
      ST_SPOS_X: num_s = (-pan_xw) <<< SCALE_FRAC_BITS;
      ST_SLEN_X: num_s = cxw <<< SCALE_FRAC_BITS;
      ST_SPOS_Y: num_s = (-pan_yw) <<< SCALE_FRAC_BITS;
      ST_SLEN_Y: num_s = cyw <<< SCALE_FRAC_BITS;
      ST_MAP_X: num_s = ((WIDE_W'(px_r) <<< OFS_FRAC) - pan_xw) <<< SCALE_FRAC_BITS;
      ST_MAP_Y: num_s = ((WIDE_W'(py_r) <<< OFS_FRAC) - pan_yw) <<< SCALE_FRAC_BITS;
      default: ;
    endcase
  end

  assign num_abs = num_s[WIDE_W-1] ? -num_s : num_s;

  always_comb begin
    unique case (state_r)
      ST_ZOOM_DIV, ST_FIT_X, ST_FIT_Y, ST_PAN_X, ST_PAN_Y, ST_SPOS_X, ST_SLEN_X,
      ST_SPOS_Y, ST_SLEN_Y, ST_MAP_X, ST_MAP_Y: is_div = 1'b1;
      default: is_div = 1'b0;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall      = (state_r != ST_IDLE);
    out_valid     = (state_r == ST_OUT);
    div_req.start = is_div && !launched_r;
    div_req.neg   = num_s[WIDE_W-1];
    div_req.mag   = num_abs[NUM_W-1:0];
    div_req.den   = den_v;
  end

  pzv_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        case (req_r)
          REQ_LAYOUT:   state_nxt = (sizes_ok && fit_r) ? ST_FIT_X : ST_SHOWN_X;
          REQ_ZOOM_IN:  state_nxt = (scale_r < ZOOM_HI) ? ST_ZOOM_DIV : ST_OUT;
          REQ_ZOOM_OUT: state_nxt = (scale_r > ZOOM_LO) ? ST_ZOOM_DIV : ST_OUT;
          REQ_MOVE:     state_nxt = ST_RECT_X;
          REQ_FIT:      state_nxt = (!fit_r && sizes_ok) ? ST_FIT_X : ST_OUT;
          REQ_MAP:      state_nxt = ST_MAP_X;
          default:      state_nxt = ST_OUT;
        endcase
      end
      ST_ZOOM_DIV: if (div_done) state_nxt = ST_PAN_X;
      ST_FIT_X:    if (div_done) state_nxt = ST_FIT_Y;
      ST_FIT_Y:    if (div_done) state_nxt = ST_PAN_X;
      ST_PAN_X:    if (div_done) state_nxt = ST_PAN_Y;
      ST_PAN_Y:    if (div_done) state_nxt = ST_SHOWN_X;
      ST_SHOWN_X:  state_nxt = ST_SHOWN_Y;
      ST_SHOWN_Y:  state_nxt = ST_RECT_X;
      ST_RECT_X:   state_nxt = big_x ? ST_SPOS_X : ST_RECT_Y;
      ST_SPOS_X:   if (div_done) state_nxt = ST_SLEN_X;
      ST_SLEN_X:   if (div_done) state_nxt = ST_RECT_Y;
      ST_RECT_Y:   state_nxt = big_y ? ST_SPOS_Y : ST_OUT;
      ST_SPOS_Y:   if (div_done) state_nxt = ST_SLEN_Y;
      ST_SLEN_Y:   if (div_done) state_nxt = ST_OUT;
      ST_MAP_X:    if (div_done) state_nxt = ST_MAP_Y;
      ST_MAP_Y:    if (div_done) state_nxt = ST_OUT;
      ST_OUT:      if (!out_stall) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      launched_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_req.start) launched_r <= 1'b1;
      else if (div_done) launched_r <= 1'b0;
    end
  end

  // Capture the request word
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      req_r <= req_t'(in_req_type);
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      ptx_r <= in_point_x;
      pty_r <= in_point_y;
    end else if (state_r == ST_FIT_X && div_done) begin
      ptx_r <= 16'(cw_r >> 1);
      pty_r <= 16'(ch_r >> 1);
    end
    if (state_r == ST_ZOOM_DIV && div_done) tgt_r <= sat_scale(qw);
    else if (state_r == ST_FIT_X && div_done) tgt_r <= sat_scale(qw);
    else if (state_r == ST_FIT_Y && div_done && sat_scale(qw) < tgt_r)
      tgt_r <= sat_scale(qw);
  end

  // Viewport state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= '0; ih_r <= '0; cw_r <= '0; ch_r <= '0;
      pan_x_r <= '0; pan_y_r <= '0;
      scale_r <= SCALE_ONE;
      shown_w_r <= '0; shown_h_r <= '0;
      src_x_r <= '0; src_y_r <= '0; src_w_r <= '0; src_h_r <= '0;
      dst_x_r <= '0; dst_y_r <= '0; dst_w_r <= '0; dst_h_r <= '0;
      map_x_r <= '0; map_y_r <= '0;
      fit_r <= 1'b1;
      laid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          2'd0: iw_r <= cfg_wdata;
          2'd1: ih_r <= cfg_wdata;
          2'd2: cw_r <= cfg_wdata;
          2'd3: ch_r <= cfg_wdata;
        endcase
      end
      unique case (state_r)
        ST_IDLE: if (in_valid) begin
          map_x_r <= '0;
          map_y_r <= '0;
        end
        ST_DISPATCH: begin
          case (req_r)
            REQ_LAYOUT: begin
              if (!laid_r) begin
                pan_x_r <= PAN_W'(($signed(WIDE_W'(cw_r)) - $signed(WIDE_W'(iw_r)))
                                  <<< (OFS_FRAC - 1));
                pan_y_r <= PAN_W'(($signed(WIDE_W'(ch_r)) - $signed(WIDE_W'(ih_r)))
                                  <<< (OFS_FRAC - 1));
              end
              if (sizes_ok) laid_r <= 1'b1;
            end
            REQ_ZOOM_IN, REQ_ZOOM_OUT, REQ_FREE: fit_r <= 1'b0;
            REQ_MOVE: begin
              pan_x_r <= sat32(pan_xw + (WIDE_W'(px_r) <<< OFS_FRAC));
              pan_y_r <= sat32(pan_yw + (WIDE_W'(py_r) <<< OFS_FRAC));
            end
            REQ_FIT: fit_r <= 1'b1;
            default: ;
          endcase
        end
        ST_PAN_X: if (div_done)
          pan_x_r <= sat32((WIDE_W'(ptx_r) <<< OFS_FRAC) + qw);
        ST_PAN_Y: if (div_done) begin
          pan_y_r <= sat32((WIDE_W'(pty_r) <<< OFS_FRAC) + qw);
          scale_r <= tgt_r;
        end
        ST_SHOWN_X: shown_w_r <= shown_prod[SCALE_W+DIM_BITS-1:SHOWN_SH];
        ST_SHOWN_Y: shown_h_r <= shown_prod[SCALE_W+DIM_BITS-1:SHOWN_SH];
        ST_RECT_X: begin
          if (!big_x) begin
            pan_x_r <= PAN_W'((cxw - shw) >>> 1);
            src_x_r <= '0;
            src_w_r <= rect_clamp($signed(WIDE_W'({iw_r, 8'b0})));
            dst_x_r <= rect_clamp((cxw - shw) >>> 1);
            dst_w_r <= rect_clamp(shw);
          end else begin
            if (pan_xw > 0) pan_x_r <= '0;
            else if (shw + pan_xw < cxw) pan_x_r <= PAN_W'(cxw - shw);
            dst_x_r <= '0;
            dst_w_r <= rect_clamp(cxw);
          end
        end
        ST_SPOS_X: if (div_done) src_x_r <= rect_clamp(qw);
        ST_SLEN_X: if (div_done) src_w_r <= rect_clamp(qw);
        ST_RECT_Y: begin
          if (!big_y) begin
            pan_y_r <= PAN_W'((cyw - shh) >>> 1);
            src_y_r <= '0;
            src_h_r <= rect_clamp($signed(WIDE_W'({ih_r, 8'b0})));
            dst_y_r <= rect_clamp((cyw - shh) >>> 1);
            dst_h_r <= rect_clamp(shh);
          end else begin
            if (pan_yw > 0) pan_y_r <= '0;
            else if (shh + pan_yw < cyw) pan_y_r <= PAN_W'(cyw - shh);
            dst_y_r <= '0;
            dst_h_r <= rect_clamp(cyw);
          end
        end
        ST_SPOS_Y: if (div_done) src_y_r <= rect_clamp(qw);
        ST_SLEN_Y: if (div_done) src_h_r <= rect_clamp(qw);
        ST_MAP_X: if (div_done) map_x_r <= sat32(qw);
        ST_MAP_Y: if (div_done) map_y_r <= sat32(qw);
        default: ;
      endcase
    end
  end

  // Drive the result word
  assign out_src_x      = src_x_r;
  assign out_src_y      = src_y_r;
  assign out_src_w      = src_w_r;
  assign out_src_h      = src_h_r;
  assign out_dst_x      = dst_x_r;
  assign out_dst_y      = dst_y_r;
  assign out_dst_w      = dst_w_r;
  assign out_dst_h      = dst_h_r;
  assign out_scale_now  = scale_r;
  assign out_image_x    = $signed(map_x_r);
  assign out_image_y    = $signed(map_y_r);
  assign out_fit_active = fit_r;

endmodule
`default_nettype wire
